// ===== sv/vtn_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vtn_pkg;

	// Default fraction bits of the Q format
	localparam int FRAC_BITS_DEF = 16;
	// Field widths
	localparam int COORD_W   = 32;
	localparam int PAIR_W    = 64;
	localparam int NUM_PAIRS = 8;
	localparam int IDX_W     = 3;
	// Exact clip sum: four 64-bit terms (three products and a translation), two growth bits
	localparam int CLIP_W    = 66;
	// Quotient bits kept by the divider: 32-bit result plus one guard bit
	localparam int QUO_W     = 33;

	localparam logic [COORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] SAT_MIN = 32'h8000_0000;

	// Flags and the w-zero results that ride alongside the divider
	typedef struct packed {
		logic                    wz;
		logic                    last;
		logic [2:0]              neg;
		logic [2:0]              big;
		logic [2:0]              wz_ovf;
		logic [2:0][COORD_W-1:0] wz_res;
	} side_t;

	// Reset value of each coefficient pair: identity matrix at 16 fraction bits
	function automatic logic [PAIR_W-1:0] pair_rst(input logic [IDX_W-1:0] k);
		logic [PAIR_W-1:0] v;
		case (k)
			3'd0: v = 64'h0000_0000_0001_0000;
			3'd2: v = 64'h0001_0000_0000_0000;
			3'd5: v = 64'h0000_0000_0001_0000;
			3'd7: v = 64'h0001_0000_0000_0000;
			default: v = '0;
		endcase
		return v;
	endfunction

	// Signed 32 x 32 product, exact in 64 bits
	function automatic logic signed [2*COORD_W-1:0] smul(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		logic signed [2*COORD_W-1:0] p;
		p = a * b;
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== sv/vertex_transform_ndc_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: 4 transform stages, 33 one-bit restoring divider stages and 1 output
// stage lie between vertex request and ndc request.
// Throughput: one vertex per cycle; a stall at the output holds each stage
// only as far as the bubbles ahead of it allow.
// Reset (arst_n low, async): pipeline empties, matrix returns to identity.
module vertex_transform_ndc_core #(
	parameter int FRACTION_BITS = vtn_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [vtn_pkg::IDX_W-1:0]           cfg_index,
	input  logic [vtn_pkg::PAIR_W-1:0]          cfg_data,
	input  logic                                vtx_valid,
	output logic                                vtx_ready,
	input  logic signed [vtn_pkg::COORD_W-1:0]  vertex_x,
	input  logic signed [vtn_pkg::COORD_W-1:0]  vertex_y,
	input  logic signed [vtn_pkg::COORD_W-1:0]  vertex_z,
	input  logic                                last_in,
	output logic                                ndc_valid,
	input  logic                                ndc_ready,
	output logic signed [vtn_pkg::COORD_W-1:0]  ndc_x,
	output logic signed [vtn_pkg::COORD_W-1:0]  ndc_y,
	output logic signed [vtn_pkg::COORD_W-1:0]  ndc_z,
	output logic                                w_zero,
	output logic                                overflow,
	output logic                                last_out
);

	localparam int CRD = vtn_pkg::COORD_W;
	localparam int CW  = vtn_pkg::CLIP_W;
	localparam int QW  = vtn_pkg::QUO_W;
	localparam int NW  = CW + FRACTION_BITS;
	localparam int TW  = NW - QW;
	localparam int PW  = 2 * CRD;

	// Matrix registers
	logic [vtn_pkg::PAIR_W-1:0] coef_q [vtn_pkg::NUM_PAIRS];
	logic signed [CRD-1:0]      mat [16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < vtn_pkg::NUM_PAIRS; k++) begin
				coef_q[k] <= vtn_pkg::pair_rst(vtn_pkg::IDX_W'(k));
			end
		end else if (cfg_we) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	// Entry e: pair e/2, odd entries in the upper half
	always_comb begin
		for (int e = 0; e < 16; e++) begin
			mat[e] = (e % 2 == 1) ? coef_q[e/2][2*CRD-1:CRD] : coef_q[e/2][CRD-1:0];
		end
	end

	// Stage valids and enables
	logic            v_s1, v_s2, v_s3;
	logic            vd_sd [QW+1];
	logic            en1, en2, en3, en_out;
	logic            en_d [QW+1];

	always_comb begin
		en_out = !ndc_valid || ndc_ready;
		en_d[QW] = !vd_sd[QW] || en_out;
		for (int j = QW - 1; j >= 0; j--) begin
			en_d[j] = !vd_sd[j] || en_d[j+1];
		end
		en3 = !v_s3 || en_d[0];
		en2 = !v_s2 || en3;
		en1 = !v_s1 || en2;
	end

	assign vtx_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			for (int j = 0; j <= QW; j++) begin
				vd_sd[j] <= 1'b0;
			end
			ndc_valid <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= vtx_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en_d[0]) begin
				vd_sd[0] <= v_s3;
			end
			for (int j = 1; j <= QW; j++) begin
				if (en_d[j]) begin
					vd_sd[j] <= vd_sd[j-1];
				end
			end
			if (en_out) begin
				ndc_valid <= vd_sd[QW];
			end
		end
	end

	// Stage 1: products and translation terms
	logic signed [PW-1:0] prx_s1 [4];
	logic signed [PW-1:0] pry_s1 [4];
	logic signed [PW-1:0] prz_s1 [4];
	logic signed [PW-1:0] trn_s1 [4];
	logic                 last_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int r = 0; r < 4; r++) begin
				prx_s1[r] <= vtn_pkg::smul(mat[r], vertex_x);
				pry_s1[r] <= vtn_pkg::smul(mat[4+r], vertex_y);
				prz_s1[r] <= vtn_pkg::smul(mat[8+r], vertex_z);
				trn_s1[r] <= PW'(mat[12+r]) <<< FRACTION_BITS;
			end
			last_s1 <= last_in;
		end
	end

	// Stage 2: exact clip sums
	logic signed [CW-1:0] clip_s2 [4];
	logic                 last_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int r = 0; r < 4; r++) begin
				clip_s2[r] <= CW'(prx_s1[r]) + CW'(pry_s1[r]) + CW'(prz_s1[r])
					+ CW'(trn_s1[r]);
			end
			last_s2 <= last_s1;
		end
	end

	// Stage 3: magnitudes, signs, and the w-zero fallback
	logic                 wneg;
	logic [CW-1:0]        wmag;
	logic                 vneg [3];
	logic [CW-1:0]        vmag [3];
	logic signed [CW-1:0] shv [3];
	logic [CRD-1:0]       wzr [3];
	logic                 wzo [3];

	always_comb begin
		wneg = clip_s2[3][CW-1];
		wmag = wneg ? CW'(-clip_s2[3]) : CW'(clip_s2[3]);
		for (int c = 0; c < 3; c++) begin
			vneg[c] = clip_s2[c][CW-1];
			vmag[c] = vneg[c] ? CW'(-clip_s2[c]) : CW'(clip_s2[c]);
			shv[c]  = clip_s2[c] >>> FRACTION_BITS;
			// fits when all bits above bit 31 match the sign
			if ((&shv[c][CW-1:CRD-1]) || !(|shv[c][CW-1:CRD-1])) begin
				wzr[c] = shv[c][CRD-1:0];
				wzo[c] = 1'b0;
			end else begin
				wzr[c] = shv[c][CW-1] ? vtn_pkg::SAT_MIN : vtn_pkg::SAT_MAX;
				wzo[c] = 1'b1;
			end
		end
	end

	logic [CW-1:0]   dvs_s3;
	logic [CW-1:0]   vmag_s3 [3];
	vtn_pkg::side_t  side_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			dvs_s3       <= wmag;
			side_s3.wz   <= (clip_s2[3] == '0);
			side_s3.last <= last_s2;
			side_s3.big  <= '0;
			for (int c = 0; c < 3; c++) begin
				vmag_s3[c]        <= vmag[c];
				side_s3.neg[c]    <= vneg[c] ^ wneg;
				side_s3.wz_ovf[c] <= wzo[c];
				side_s3.wz_res[c] <= wzr[c];
			end
		end
	end

	// Stage 4 (divider entry) and the divider stages
	logic [CW-1:0]  rem_sd  [QW+1][3];
	logic [QW-1:0]  nlo_sd  [QW+1][3];
	logic [QW-1:0]  quo_sd  [QW+1][3];
	logic [CW-1:0]  dsr_sd  [QW+1];
	vtn_pkg::side_t side_sd [QW+1];

	logic [NW-1:0]  num [3];
	logic [TW-1:0]  ntop [3];
	logic           big [3];
	vtn_pkg::side_t side_in;

	// Quotient must stay below 2^QW: otherwise the result saturates
	always_comb begin
		side_in = side_s3;
		for (int c = 0; c < 3; c++) begin
			num[c]  = NW'(vmag_s3[c]) << FRACTION_BITS;
			ntop[c] = num[c][NW-1:QW];
			big[c]  = CW'(ntop[c]) >= dvs_s3;
			side_in.big[c] = big[c];
		end
	end

	// One quotient bit per stage
	logic [CW:0]   trial;
	logic [CW:0]   diff;
	logic [CW-1:0] rem_nx [QW+1][3];
	logic          ge_nx  [QW+1][3];

	always_comb begin
		trial = '0;
		diff  = '0;
		for (int c = 0; c < 3; c++) begin
			rem_nx[0][c] = '0;
			ge_nx[0][c]  = 1'b0;
		end
		for (int j = 1; j <= QW; j++) begin
			for (int c = 0; c < 3; c++) begin
				trial = {rem_sd[j-1][c], nlo_sd[j-1][c][QW-1]};
				diff  = trial - {1'b0, dsr_sd[j-1]};
				ge_nx[j][c]  = trial >= {1'b0, dsr_sd[j-1]};
				rem_nx[j][c] = ge_nx[j][c] ? diff[CW-1:0] : trial[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_d[0]) begin
			dsr_sd[0] <= dvs_s3;
			side_sd[0] <= side_in;
			for (int c = 0; c < 3; c++) begin
				rem_sd[0][c]     <= CW'(ntop[c]);
				nlo_sd[0][c]     <= num[c][QW-1:0];
				quo_sd[0][c]     <= '0;
			end
		end
		for (int j = 1; j <= QW; j++) begin
			if (en_d[j]) begin
				dsr_sd[j]  <= dsr_sd[j-1];
				side_sd[j] <= side_sd[j-1];
				for (int c = 0; c < 3; c++) begin
					rem_sd[j][c] <= rem_nx[j][c];
					nlo_sd[j][c] <= nlo_sd[j-1][c] << 1;
					quo_sd[j][c] <= {quo_sd[j-1][c][QW-2:0], ge_nx[j][c]};
				end
			end
		end
	end

	// Output stage: sign, saturation, w-zero select
	vtn_pkg::side_t sd_f;
	logic [QW-1:0]  qv [3];
	logic           lim [3];
	logic [CRD-1:0] res [3];
	logic           ovf [3];

	always_comb begin
		sd_f = side_sd[QW];
		for (int c = 0; c < 3; c++) begin
			qv[c] = quo_sd[QW][c];
			if (sd_f.neg[c]) begin
				lim[c] = qv[c][QW-1] || (qv[c][CRD-1] && (|qv[c][CRD-2:0]));
			end else begin
				lim[c] = qv[c][QW-1] || qv[c][CRD-1];
			end
			if (sd_f.wz) begin
				res[c] = sd_f.wz_res[c];
				ovf[c] = sd_f.wz_ovf[c];
			end else if (sd_f.big[c] || lim[c]) begin
				res[c] = sd_f.neg[c] ? vtn_pkg::SAT_MIN : vtn_pkg::SAT_MAX;
				ovf[c] = 1'b1;
			end else begin
				res[c] = sd_f.neg[c] ? -qv[c][CRD-1:0] : qv[c][CRD-1:0];
				ovf[c] = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_out) begin
			ndc_x    <= res[0];
			ndc_y    <= res[1];
			ndc_z    <= res[2];
			w_zero   <= sd_f.wz;
			overflow <= ovf[0] || ovf[1] || ovf[2];
			last_out <= sd_f.last;
		end
	end

endmodule

`default_nettype wire

// ===== sv/vtn_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vtn_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        vtx_valid,
	input logic        vtx_ready,
	input logic        ndc_valid,
	input logic        ndc_ready,
	input logic [31:0] ndc_x,
	input logic [31:0] ndc_y,
	input logic [31:0] ndc_z,
	input logic        overflow
);

	// A waiting result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ndc_valid && !ndc_ready |=> ndc_valid)
		else $error("ndc request dropped while stalled");

	// A waiting result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		ndc_valid && !ndc_ready |=> $stable(ndc_x) && $stable(ndc_y) && $stable(ndc_z))
		else $error("ndc payload changed while stalled");

	// Input back-pressure only comes from a blocked output
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!vtx_ready |-> ndc_valid && !ndc_ready)
		else $error("vertex request refused without output stall");

	// Overflow means some coordinate sits at a rail
	a_ovf_rail: assert property (@(posedge clk) disable iff (!arst_n)
		ndc_valid && overflow |->
		ndc_x == 32'h7FFF_FFFF || ndc_x == 32'h8000_0000 ||
		ndc_y == 32'h7FFF_FFFF || ndc_y == 32'h8000_0000 ||
		ndc_z == 32'h7FFF_FFFF || ndc_z == 32'h8000_0000)
		else $error("overflow flagged with no saturated coordinate");

endmodule

bind vertex_transform_ndc_core vtn_chk u_vtn_chk (.*);

`default_nettype wire
